// File: rtl/core/ifp_pkg.sv
`timescale 1ns / 1ps

package ifp_pkg;

  localparam int unsigned FrameBytes = 11;
  localparam int unsigned PosW       = $clog2(FrameBytes);
  localparam int unsigned PayBytes   = FrameBytes - 3;
  localparam int unsigned PayIdxW    = $clog2(PayBytes);
  localparam int unsigned NumWords   = PayBytes / 2;
  localparam int unsigned AxisW      = 23;
  localparam int unsigned ProdW      = AxisW + 1;

  localparam logic [7:0] HdrByte = 8'h55;
  localparam logic [7:0] TypeAcc = 8'h51;
  localparam logic [7:0] TypeGyr = 8'h52;
  localparam logic [7:0] TypeAng = 8'h53;

  localparam logic [PosW-1:0] PosHdr  = PosW'(0);
  localparam logic [PosW-1:0] PosType = PosW'(1);
  localparam logic [PosW-1:0] PosLast = PosW'(FrameBytes - 1);

  typedef enum logic [1:0] {
    KindAcc = 2'd0,
    KindGyr = 2'd1,
    KindAng = 2'd2
  } frame_kind_e;

  typedef struct packed {
    frame_kind_e                 kind;
    logic [NumWords-1:0][15:0]   words;
  } frame_t;

  function automatic logic signed [AxisW-1:0] scale_axis(frame_kind_e kind,
                                                        logic [15:0] w);
    logic signed [ProdW-1:0] wx;
    logic signed [ProdW-1:0] p125;
    logic signed [ProdW-1:0] p45;
    logic signed [ProdW-1:0] res;
    wx   = $signed({{(ProdW-16){w[15]}}, w});
    p125 = wx * ProdW'(125);
    p45  = wx * ProdW'(45);
    unique case (kind)
      KindAcc: res = p125;
      KindGyr: res = p125 >>> 3;
      KindAng: res = p45 >>> 5;
      default: res = '0;
    endcase
    return res[AxisW-1:0];
  endfunction

endpackage

// File: rtl/core/ifp_collector.sv
`timescale 1ns / 1ps

module ifp_collector import ifp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic       buffer_start_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       frm_valid_o,
  output frame_t     frm_o,
  input  logic       frm_ready_i
);

  logic [PosW-1:0]  pos_q, pos_d, pos_w;
  logic [7:0]       sum_q, sum_d;
  logic             hdr_q, hdr_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       pay_q [PayBytes];
  logic             frm_valid_q, frm_valid_d;
  frame_t           frm_q, frm_d;
  logic             accept;
  logic             known;
  frame_kind_e      kind;
  logic [PayIdxW-1:0] pay_idx;

  assign in_ready_o = !frm_valid_q || frm_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_w      = buffer_start_i ? PosHdr : pos_q;
  assign pay_idx    = PayIdxW'(pos_w - PosW'(2));

  always_comb begin
    known = 1'b1;
    kind  = KindAcc;
    unique case (type_q)
      TypeAcc: kind = KindAcc;
      TypeGyr: kind = KindGyr;
      TypeAng: kind = KindAng;
      default: known = 1'b0;
    endcase
  end

  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    hdr_d       = hdr_q;
    type_d      = type_q;
    frm_valid_d = frm_valid_q && !frm_ready_i;
    frm_d       = frm_q;
    frm_d.kind  = kind;
    for (int k = 0; k < NumWords; k++) begin
      frm_d.words[k] = {pay_q[2*k+1], pay_q[2*k]};
    end
    if (accept) begin
      if (pos_w == PosHdr) begin
        hdr_d = (rx_byte_i == HdrByte);
        sum_d = rx_byte_i;
        pos_d = PosType;
      end else if (pos_w != PosLast) begin
        if (pos_w == PosType) begin
          type_d = rx_byte_i;
        end
        sum_d = sum_q + rx_byte_i;
        pos_d = pos_w + PosW'(1);
      end else begin
        pos_d = PosHdr;
        if (hdr_q && (sum_q == rx_byte_i) && known) begin
          frm_valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosHdr;
      sum_q       <= '0;
      hdr_q       <= 1'b0;
      type_q      <= '0;
      frm_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      hdr_q       <= hdr_d;
      type_q      <= type_d;
      frm_valid_q <= frm_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pos_w != PosHdr && pos_w != PosType && pos_w != PosLast) begin
      pay_q[pay_idx] <= rx_byte_i;
    end
    if (!frm_valid_q || frm_ready_i) begin
      frm_q <= frm_d;
    end
  end

  assign frm_valid_o = frm_valid_q;
  assign frm_o       = frm_q;

endmodule

// File: rtl/core/ifp_scaler.sv
`timescale 1ns / 1ps

module ifp_scaler import ifp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    frm_valid_i,
  input  frame_t                  frm_i,
  output logic                    frm_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              frame_kind_o,
  output logic signed [AxisW-1:0] axis_x_o,
  output logic signed [AxisW-1:0] axis_y_o,
  output logic signed [AxisW-1:0] axis_z_o,
  output logic signed [15:0]      extra_word_o
);

  logic                    out_valid_q;
  frame_kind_e             kind_q;
  logic signed [AxisW-1:0] x_q, y_q, z_q;
  logic signed [15:0]      extra_q;
  logic                    load;

  assign frm_ready_o = !out_valid_q || out_ready_i;
  assign load        = frm_valid_i && frm_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (frm_ready_o) begin
      out_valid_q <= frm_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= frm_i.kind;
      x_q     <= scale_axis(frm_i.kind, frm_i.words[0]);
      y_q     <= scale_axis(frm_i.kind, frm_i.words[1]);
      z_q     <= scale_axis(frm_i.kind, frm_i.words[2]);
      extra_q <= (frm_i.kind == KindGyr) ? 16'sd0 : $signed(frm_i.words[3]);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_kind_o = kind_q;
  assign axis_x_o     = x_q;
  assign axis_y_o     = y_q;
  assign axis_z_o     = z_q;
  assign extra_word_o = extra_q;

endmodule

// File: rtl/core/imu_frame_parser_core.sv
// A result is registered in the collector frame register after the checksum
// byte, then in the scaler output register. Throughput: one received byte per
// cycle while in_ready_o is high, set by the byte collector and its frame
// register; the scaler output register holds one result. Reset: asynchronous,
// active low; clears frame alignment, checksum and both stages' valid flags.
`timescale 1ns / 1ps

module imu_frame_parser_core import ifp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              rx_byte_i,
  input  logic                    buffer_start_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              frame_kind_o,
  output logic signed [AxisW-1:0] axis_x_o,
  output logic signed [AxisW-1:0] axis_y_o,
  output logic signed [AxisW-1:0] axis_z_o,
  output logic signed [15:0]      extra_word_o
);

  logic   frm_valid;
  logic   frm_ready;
  frame_t frm;

  ifp_collector u_collector (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (rx_byte_i),
    .buffer_start_i (buffer_start_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .frm_valid_o    (frm_valid),
    .frm_o          (frm),
    .frm_ready_i    (frm_ready)
  );

  ifp_scaler u_scaler (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frm_valid_i  (frm_valid),
    .frm_i        (frm),
    .frm_ready_o  (frm_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_kind_o (frame_kind_o),
    .axis_x_o     (axis_x_o),
    .axis_y_o     (axis_y_o),
    .axis_z_o     (axis_z_o),
    .extra_word_o (extra_word_o)
  );

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output stage");

  a_rate_no_extra : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_kind_o == KindGyr) |-> (extra_word_o == 16'sd0))
    else $error("rate beat carries a non-zero extra word");

  a_new_result_from_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(frm_valid) |-> $past(in_valid_i && in_ready_o))
    else $error("frame raised without an accepted byte");

endmodule

// File: bench/tb_imu_frame_parser_core.sv
`timescale 1ns / 1ps

module tb_imu_frame_parser_core;
  import ifp_pkg::*;

  typedef struct packed {
    frame_kind_e                 kind;
    logic signed [AxisW-1:0]     x;
    logic signed [AxisW-1:0]     y;
    logic signed [AxisW-1:0]     z;
    logic signed [15:0]          extra;
  } imu_sample_t;

  typedef enum int {
    FaultNone,
    FaultHeader,
    FaultSum,
    FaultCut
  } frame_fault_e;

  class imu_frame_checker;
    logic [PosW-1:0]   pos;
    logic [7:0]        sum;
    bit                hdr_ok;
    logic [7:0]        typ;
    logic [7:0]        pay [PayBytes];
    imu_sample_t       samples_due [$];
    int                errors;
    int                seen;

    function new();
      pos    = PosHdr;
      sum    = '0;
      hdr_ok = 1'b0;
      typ    = '0;
      foreach (pay[i]) pay[i] = '0;
      errors = 0;
      seen   = 0;
    endfunction

    function int pending();
      return samples_due.size();
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    function logic signed [AxisW-1:0] scale_word(frame_kind_e k, logic signed [15:0] w);
      int v;
      case (k)
        KindAcc: v = int'(w) * 125;
        KindGyr: v = (int'(w) * 125) >>> 3;
        KindAng: v = (int'(w) * 45) >>> 5;
        default: v = 0;
      endcase
      return v[AxisW-1:0];
    endfunction

    function void decode_frame();
      logic signed [15:0] wd [NumWords];
      imu_sample_t        s;
      for (int k = 0; k < NumWords; k++) wd[k] = {pay[2*k+1], pay[2*k]};
      case (typ)
        TypeAcc: begin
          s.kind  = KindAcc;
          s.extra = wd[3];
        end
        TypeGyr: begin
          s.kind  = KindGyr;
          s.extra = '0;
        end
        TypeAng: begin
          s.kind  = KindAng;
          s.extra = wd[3];
        end
        default: return;
      endcase
      s.x = scale_word(s.kind, wd[0]);
      s.y = scale_word(s.kind, wd[1]);
      s.z = scale_word(s.kind, wd[2]);
      samples_due.push_back(s);
    endfunction

    task take_byte(logic [7:0] b, logic start);
      if (start) pos = PosHdr;
      if (pos == PosHdr) begin
        hdr_ok = (b == HdrByte);
        sum    = b;
        pos    = PosType;
      end else if (pos != PosLast) begin
        if (pos == PosType) typ = b;
        else pay[pos - 2] = b;
        sum = sum + b;
        pos = pos + 1'b1;
      end else begin
        pos = PosHdr;
        if (hdr_ok && sum == b) decode_frame();
      end
    endtask

    task check_field(string name, int got, int want);
      if (got != want)
        report($sformatf("sample %0d: %s got %0d want %0d", seen, name, got, want));
    endtask

    task check_sample(logic [1:0] kind, logic signed [AxisW-1:0] x,
                      logic signed [AxisW-1:0] y, logic signed [AxisW-1:0] z,
                      logic signed [15:0] extra);
      imu_sample_t s;
      if (samples_due.size() == 0) begin
        report($sformatf("sample %0d arrived with none due", seen));
      end else begin
        s = samples_due.pop_front();
        check_field("frame_kind", int'(kind), int'(s.kind));
        check_field("axis_x", int'(x), int'(s.x));
        check_field("axis_y", int'(y), int'(s.y));
        check_field("axis_z", int'(z), int'(s.z));
        check_field("extra_word", int'(extra), int'(s.extra));
      end
      seen++;
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [7:0]              rx_byte_i;
  logic                    buffer_start_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [1:0]              frame_kind_o;
  logic signed [AxisW-1:0] axis_x_o;
  logic signed [AxisW-1:0] axis_y_o;
  logic signed [AxisW-1:0] axis_z_o;
  logic signed [15:0]      extra_word_o;

  imu_frame_checker chk = new();

  bit tx_quiet;
  bit hold_req;
  bit aligned;
  int bytes_sent;

  imu_frame_parser_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .buffer_start_i (buffer_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_kind_o   (frame_kind_o),
    .axis_x_o       (axis_x_o),
    .axis_y_o       (axis_y_o),
    .axis_z_o       (axis_z_o),
    .extra_word_o   (extra_word_o)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) chk.take_byte(rx_byte_i, buffer_start_i);
    if (rst_ni && out_valid_o && out_ready_i)
      chk.check_sample(frame_kind_o, axis_x_o, axis_y_o, axis_z_o, extra_word_o);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_type();
    case ($urandom_range(0, 9))
      0: return 8'($urandom);
      1, 2, 3: return TypeAcc;
      4, 5, 6: return TypeGyr;
      default: return TypeAng;
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b, logic start);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    rx_byte_i      <= b;
    buffer_start_i <= start;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(logic [7:0] typ, logic [3:0][15:0] words, bit start,
                            frame_fault_e fault);
    logic [7:0] f [FrameBytes];
    logic [7:0] sum;
    int         n;
    f[0] = HdrByte;
    if (fault == FaultHeader) begin
      f[0] = 8'($urandom);
      if (f[0] == HdrByte) f[0] = f[0] ^ 8'h01;
    end
    f[1] = typ;
    for (int k = 0; k < 4; k++) begin
      f[2 + 2*k] = words[k][7:0];
      f[3 + 2*k] = words[k][15:8];
    end
    sum = '0;
    for (int i = 0; i < FrameBytes - 1; i++) sum = sum + f[i];
    f[FrameBytes - 1] = sum;
    if (fault == FaultSum) f[FrameBytes - 1] = sum + 8'($urandom_range(1, 255));
    n = (fault == FaultCut) ? $urandom_range(1, FrameBytes - 1) : FrameBytes;
    for (int i = 0; i < n; i++) send_byte(f[i], (i == 0) && (start || !aligned));
    aligned = (fault != FaultCut);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 15);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    aligned = 1'b0;
  endtask

  task automatic random_frame(frame_fault_e fault);
    logic [3:0][15:0] w;
    for (int k = 0; k < 4; k++) w[k] = rand_word();
    if ($urandom_range(0, 11) == 0) tx_quiet = !tx_quiet;
    send_frame(rand_type(), w, $urandom_range(0, 3) == 0, fault);
  endtask

  task automatic drain_samples();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (chk.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int  gap;
    int  left;
    bit  rx_quiet;
    rx_quiet = 1'b0;
    left     = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        if (left <= 0) begin
          rx_quiet = ($urandom_range(0, 3) == 0);
          left     = $urandom_range(50, 300);
        end
        left--;
        gap = rx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int  r;
    bit  hold_done;
    bit  pause_done;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    rx_byte_i      = '0;
    buffer_start_i = 1'b0;
    out_ready_i    = 1'b0;
    tx_quiet       = 1'b0;
    hold_req       = 1'b0;
    aligned        = 1'b1;
    bytes_sent     = 0;
    hold_done      = 1'b0;
    pause_done     = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frame(TypeAcc, {16'h7fff, 16'hffff, 16'h7fff, 16'h8000}, 1'b1, FaultNone);
    send_frame(TypeGyr, {16'hffff, 16'h0001, 16'h8000, 16'h7fff}, 1'b0, FaultNone);
    send_frame(TypeAng, {16'h8000, 16'h8000, 16'h7fff, 16'hffff}, 1'b0, FaultNone);
    send_frame(TypeAcc, {16'h1234, 16'h0000, 16'h00ff, 16'hff00}, 1'b0, FaultHeader);
    send_frame(TypeGyr, {16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0}, 1'b0, FaultSum);
    send_frame(8'h50, {16'h0001, 16'h0002, 16'h0003, 16'h0004}, 1'b0, FaultNone);
    send_frame(TypeAng, {16'h0100, 16'h0200, 16'h0300, 16'h0400}, 1'b0, FaultCut);
    send_frame(TypeGyr, {16'h0000, 16'hfff8, 16'h0007, 16'hfffe}, 1'b1, FaultNone);

    while (bytes_sent < 1300) begin
      if (!hold_done && bytes_sent >= 400) begin
        hold_done = 1'b1;
        tx_quiet  = 1'b1;
        hold_req  = 1'b1;
        for (int i = 0; i < 40; i++) begin
          tx_quiet = 1'b1;
          random_frame(FaultNone);
        end
      end
      if (!pause_done && bytes_sent >= 900) begin
        pause_done = 1'b1;
        drain_samples();
      end
      r = $urandom_range(0, 99);
      if (r < 78) random_frame(FaultNone);
      else if (r < 84) random_frame(FaultSum);
      else if (r < 88) random_frame(FaultHeader);
      else if (r < 93) random_frame(FaultCut);
      else send_noise();
    end

    drain_samples();
    repeat (8) @(posedge clk_i);
    if (chk.errors == 0) begin
      $display("imu_frame_parser_core: match");
    end else begin
      $display("imu_frame_parser_core: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("imu_frame_parser_core: mismatch");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ifp_pkg.sv
rtl/core/ifp_collector.sv
rtl/core/ifp_scaler.sv
rtl/core/imu_frame_parser_core.sv
bench/tb_imu_frame_parser_core.sv
